@@ hw/rtl/slm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

   // Blink modes; the first three each own a phase counter.
   typedef enum logic [1:0] {
      MODE_SLOW     = 2'd0,
      MODE_IDLE     = 2'd1,
      MODE_TRANSFER = 2'd2,
      MODE_FULL_ON  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      EVT_NONE        = 3'd0,
      EVT_SYNC        = 3'd1,
      EVT_XFER_BEGIN  = 3'd2,
      EVT_XFER_DONE   = 3'd3,
      EVT_WRITE_DONE  = 3'd4
   } event_type;

   localparam int NUM_PHASE  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TICK_W     = 24;
   localparam int HOLD_W     = 32;
   localparam int CMP_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_ON         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_PERIOD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_ON         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PERIOD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFER_ON     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFER_PERIOD = 3'd6;

   localparam logic [HOLD_W-1:0] RST_HOLD_TICKS      = 32'd3000000;
   localparam logic [TICK_W-1:0] RST_SLOW_ON         = 24'd1000000;
   localparam logic [TICK_W-1:0] RST_SLOW_PERIOD     = 24'd2000000;
   localparam logic [TICK_W-1:0] RST_IDLE_ON         = 24'd50000;
   localparam logic [TICK_W-1:0] RST_IDLE_PERIOD     = 24'd3000000;
   localparam logic [TICK_W-1:0] RST_TRANSFER_ON     = 24'd100000;
   localparam logic [TICK_W-1:0] RST_TRANSFER_PERIOD = 24'd500000;

   typedef struct packed {
      logic [HOLD_W-1:0]                 hold_ticks;
      logic [NUM_PHASE-1:0][TICK_W-1:0] on_ticks;
      logic [NUM_PHASE-1:0][TICK_W-1:0] period_ticks;
   } cfg_type;

endpackage

`default_nettype wire

@@ hw/rtl/slm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface slm_req_if;
   logic       valid;
   logic       ready;
   logic       button_pressed;
   logic [2:0] event_req;

   modport source (output valid, output button_pressed, output event_req, input ready);
   modport sink   (input valid, input button_pressed, input event_req, output ready);
endinterface

interface slm_rsp_if;
   logic       valid;
   logic       ready;
   logic       led;
   logic       shutdown_request;
   logic [1:0] mode;

   modport source (output valid, output led, output shutdown_request, output mode,
                   input ready);
   modport sink   (input valid, input led, input shutdown_request, input mode,
                   output ready);
endinterface

interface slm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/status_led_mode_and_hold_shutdown.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Status LED blink-mode and hold-to-shutdown monitor. Each req transaction is
// one timer tick carrying the button level and an optional event; each tick
// yields exactly one rsp transaction with the LED level, the latched shutdown
// flag and the current mode. A new tick is taken every cycle while rsp_ch is
// ready: the tick is held in the input register while its state update and
// result are computed, then lands in the result register, which presents it
// on rsp_ch, so the block sustains one tick per clock while rsp_ch is ready.
// While rsp_ch stalls, the result register and then the input register hold,
// and req_ch drops ready. The csr_ch port is always ready; writing a period
// register restarts that mode's phase counter. Write configuration only while
// no tick is in flight. PHASE_WIDTH sets the width of the three phase counters
// (16 to 32).

module status_led_mode_and_hold_shutdown
   import slm_pkg::*;
#(
   parameter int PHASE_WIDTH = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   slm_req_if.sink   req_ch,
   slm_rsp_if.source rsp_ch,
   slm_csr_if.sink   csr_ch
);

   cfg_type              cfg;
   logic [NUM_PHASE-1:0] period_clear;

   logic      s1_valid_ff;
   logic      button_ff;
   event_type event_ff;

   mode_type  mode_ff;
   logic      sync_seen_ff;
   mode_type  mode_in;
   logic      sync_seen_in;

   logic      rsp_valid_ff;
   logic      led_ff;
   logic      shutdown_ff;
   mode_type  rsp_mode_ff;

   logic      advance;
   logic      led_in;
   logic      shutdown_in;

   // Move the held tick into the result register when that slot frees up.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.led              = led_ff;
   assign rsp_ch.shutdown_request = shutdown_ff;
   assign rsp_ch.mode             = rsp_mode_ff;

   slm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_ch),
      .cfg          (cfg),
      .period_clear (period_clear)
   );

   slm_hold u_hold (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pressed    (button_ff),
      .hold_ticks (cfg.hold_ticks),
      .shutdown   (shutdown_in)
   );

   slm_phase #(
      .PHASE_WIDTH (PHASE_WIDTH)
   ) u_phase (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .period_clear (period_clear),
      .on_ticks     (cfg.on_ticks),
      .period_ticks (cfg.period_ticks),
      .mode         (mode_in),
      .led          (led_in)
   );

   always_comb begin
      mode_in      = mode_ff;
      sync_seen_in = sync_seen_ff;
      unique case (event_ff)
         EVT_SYNC: begin
            mode_in      = MODE_IDLE;
            sync_seen_in = 1'b1;
         end
         EVT_XFER_BEGIN: mode_in = MODE_TRANSFER;
         EVT_XFER_DONE:  mode_in = sync_seen_ff ? MODE_IDLE : MODE_SLOW;
         EVT_WRITE_DONE: mode_in = MODE_FULL_ON;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_SLOW;
         sync_seen_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            sync_seen_ff <= sync_seen_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         button_ff <= req_ch.button_pressed;
         event_ff  <= event_type'(req_ch.event_req);
      end
      if (advance) begin
         led_ff      <= led_in;
         shutdown_ff <= shutdown_in;
         rsp_mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/slm_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slm_csr
   import slm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   slm_csr_if.sink             csr,
   output cfg_type             cfg,
   output logic [NUM_PHASE-1:0] period_clear
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr.ready = 1'b1;
   assign wr_en     = csr.valid;
   assign cfg       = cfg_ff;

   // A period write restarts that mode's phase counter.
   assign period_clear[0] = wr_en && (csr.index == CSR_SLOW_PERIOD);
   assign period_clear[1] = wr_en && (csr.index == CSR_IDLE_PERIOD);
   assign period_clear[2] = wr_en && (csr.index == CSR_TRANSFER_PERIOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks      <= RST_HOLD_TICKS;
         cfg_ff.on_ticks[0]     <= RST_SLOW_ON;
         cfg_ff.period_ticks[0] <= RST_SLOW_PERIOD;
         cfg_ff.on_ticks[1]     <= RST_IDLE_ON;
         cfg_ff.period_ticks[1] <= RST_IDLE_PERIOD;
         cfg_ff.on_ticks[2]     <= RST_TRANSFER_ON;
         cfg_ff.period_ticks[2] <= RST_TRANSFER_PERIOD;
      end else if (wr_en) begin
         unique case (csr.index)
            CSR_HOLD_TICKS:      cfg_ff.hold_ticks      <= csr.data;
            CSR_SLOW_ON:         cfg_ff.on_ticks[0]     <= csr.data[TICK_W-1:0];
            CSR_SLOW_PERIOD:     cfg_ff.period_ticks[0] <= csr.data[TICK_W-1:0];
            CSR_IDLE_ON:         cfg_ff.on_ticks[1]     <= csr.data[TICK_W-1:0];
            CSR_IDLE_PERIOD:     cfg_ff.period_ticks[1] <= csr.data[TICK_W-1:0];
            CSR_TRANSFER_ON:     cfg_ff.on_ticks[2]     <= csr.data[TICK_W-1:0];
            CSR_TRANSFER_PERIOD: cfg_ff.period_ticks[2] <= csr.data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/slm_hold.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slm_hold
   import slm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              pressed,
   input  wire logic [HOLD_W-1:0] hold_ticks,
   output logic                   shutdown
);

   logic              press_active_ff;
   logic [HOLD_W-1:0] hold_count_ff;
   logic              shutdown_ff;
   logic [HOLD_W-1:0] hold_count_in;
   logic              shutdown_in;

   always_comb begin
      hold_count_in = '0;
      shutdown_in   = shutdown_ff;
      if (pressed) begin
         if (press_active_ff) begin
            // saturate at all ones
            hold_count_in = (&hold_count_ff) ? hold_count_ff : hold_count_ff + 1'b1;
         end
         if (hold_count_in > hold_ticks) begin
            shutdown_in = 1'b1;
         end
      end
   end

   assign shutdown = shutdown_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_active_ff <= 1'b0;
         hold_count_ff   <= '0;
         shutdown_ff     <= 1'b0;
      end else if (advance) begin
         press_active_ff <= pressed;
         hold_count_ff   <= hold_count_in;
         shutdown_ff     <= shutdown_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/slm_phase.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slm_phase
   import slm_pkg::*;
#(
   parameter int PHASE_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [NUM_PHASE-1:0]          period_clear,
   input  wire logic [NUM_PHASE-1:0][TICK_W-1:0] on_ticks,
   input  wire logic [NUM_PHASE-1:0][TICK_W-1:0] period_ticks,
   input  wire mode_type                      mode,
   output logic                               led
);

   logic [PHASE_WIDTH-1:0] phase_ff [NUM_PHASE];
   logic [PHASE_WIDTH-1:0] phase_in [NUM_PHASE];
   logic [3:0]             lit;

   always_comb begin
      for (int i = 0; i < NUM_PHASE; i++) begin
         phase_in[i] = phase_ff[i] + 1'b1;
         if (CMP_W'(phase_in[i]) >= CMP_W'(period_ticks[i])) begin
            phase_in[i] = '0;
         end
         lit[i] = CMP_W'(phase_ff[i]) < CMP_W'(on_ticks[i]);
      end
      lit[3] = 1'b1;
   end

   assign led = lit[mode];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PHASE; i++) begin
            phase_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_PHASE; i++) begin
            if (period_clear[i]) begin
               phase_ff[i] <= '0;
            end else if (advance) begin
               phase_ff[i] <= phase_in[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ test/status_led_mode_and_hold_shutdown_tb.sv @@
`timescale 1ns / 1ps

module status_led_mode_and_hold_shutdown_tb;
   import slm_pkg::*;

   localparam int PHASE_W     = 24;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_CAP   = 40;

   typedef struct packed {
      logic     led;
      logic     shutdown_request;
      mode_type mode;
   } tick_result_type;

   logic clock;
   logic reset;

   slm_req_if req_ch ();
   slm_rsp_if rsp_ch ();
   slm_csr_if csr_ch ();

   status_led_mode_and_hold_shutdown #(.PHASE_WIDTH(PHASE_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow of the block's configuration and state
   logic [HOLD_W-1:0]  hold_limit;
   logic [TICK_W-1:0]  lit_ticks   [NUM_PHASE];
   logic [TICK_W-1:0]  period_len  [NUM_PHASE];
   logic [PHASE_W-1:0] phase_cnt   [NUM_PHASE];
   mode_type           blink_mode;
   logic               sync_seen;
   logic               press_held;
   logic [HOLD_W-1:0]  held_ticks;
   logic               shutdown_flag;

   tick_result_type tick_expect_q[$];

   int  error_count;
   int  cycle_count;
   int  ticks_sent;
   int  results_checked;
   int  csr_writes;
   int  stall_left;
   bit  calm;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  tick_expect_q.size());
         $display("status_led_mode_and_hold_shutdown regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_CAP)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Receiver side: random ready bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 2);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (tick_expect_q.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = tick_expect_q.pop_front();
            results_checked++;
            if (rsp_ch.led !== want.led)
               report_mismatch("led", int'(rsp_ch.led), int'(want.led));
            if (rsp_ch.shutdown_request !== want.shutdown_request)
               report_mismatch("shutdown_request", int'(rsp_ch.shutdown_request),
                               int'(want.shutdown_request));
            if (rsp_ch.mode !== want.mode)
               report_mismatch("mode", int'(rsp_ch.mode), int'(want.mode));
         end
      end
   end

   task automatic predict_tick(input logic pressed, input logic [2:0] evt);
      tick_result_type    res;
      logic [PHASE_W-1:0] nx;
      if (pressed) begin
         if (!press_held) begin
            press_held = 1'b1;
            held_ticks = '0;
         end else if (held_ticks != '1) begin
            held_ticks = held_ticks + 1'b1;
         end
         if (held_ticks > hold_limit)
            shutdown_flag = 1'b1;
      end else begin
         press_held = 1'b0;
         held_ticks = '0;
      end
      case (evt)
         EVT_SYNC: begin
            blink_mode = MODE_IDLE;
            sync_seen  = 1'b1;
         end
         EVT_XFER_BEGIN: blink_mode = MODE_TRANSFER;
         EVT_XFER_DONE:  blink_mode = sync_seen ? MODE_IDLE : MODE_SLOW;
         EVT_WRITE_DONE: blink_mode = MODE_FULL_ON;
         default: ;
      endcase
      if (blink_mode == MODE_FULL_ON)
         res.led = 1'b1;
      else
         res.led = (phase_cnt[blink_mode] < lit_ticks[blink_mode]);
      res.shutdown_request = shutdown_flag;
      res.mode             = blink_mode;
      // advance every counter, wrap at its period
      for (int i = 0; i < NUM_PHASE; i++) begin
         nx = phase_cnt[i] + 1'b1;
         if (nx >= period_len[i])
            nx = '0;
         phase_cnt[i] = nx;
      end
      tick_expect_q.push_back(res);
   endtask

   task automatic send_tick(input logic pressed, input logic [2:0] evt);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.button_pressed <= pressed;
      req_ch.event_req      <= evt;
      do @(posedge clock); while (!req_ch.ready);
      predict_tick(pressed, evt);
      ticks_sent++;
   endtask

   // Drop valid and wait for every outstanding result
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_HOLD_TICKS: hold_limit = data;
         CSR_SLOW_ON: lit_ticks[MODE_SLOW] = data[TICK_W-1:0];
         CSR_IDLE_ON: lit_ticks[MODE_IDLE] = data[TICK_W-1:0];
         CSR_TRANSFER_ON: lit_ticks[MODE_TRANSFER] = data[TICK_W-1:0];
         CSR_SLOW_PERIOD: begin
            period_len[MODE_SLOW] = data[TICK_W-1:0];
            phase_cnt[MODE_SLOW]  = '0;
         end
         CSR_IDLE_PERIOD: begin
            period_len[MODE_IDLE] = data[TICK_W-1:0];
            phase_cnt[MODE_IDLE]  = '0;
         end
         CSR_TRANSFER_PERIOD: begin
            period_len[MODE_TRANSFER] = data[TICK_W-1:0];
            phase_cnt[MODE_TRANSFER]  = '0;
         end
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic write_blink(input logic [TICK_W-1:0] slow_on, input logic [TICK_W-1:0] slow_per,
                              input logic [TICK_W-1:0] idle_on, input logic [TICK_W-1:0] idle_per,
                              input logic [TICK_W-1:0] xfer_on, input logic [TICK_W-1:0] xfer_per);
      write_csr(CSR_SLOW_ON, CSR_DATA_W'(slow_on));
      write_csr(CSR_SLOW_PERIOD, CSR_DATA_W'(slow_per));
      write_csr(CSR_IDLE_ON, CSR_DATA_W'(idle_on));
      write_csr(CSR_IDLE_PERIOD, CSR_DATA_W'(idle_per));
      write_csr(CSR_TRANSFER_ON, CSR_DATA_W'(xfer_on));
      write_csr(CSR_TRANSFER_PERIOD, CSR_DATA_W'(xfer_per));
   endtask

   function automatic logic [TICK_W-1:0] pick_ticks();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return '1;
         2: return TICK_W'($urandom);
         default: return TICK_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [2:0] pick_event();
      case ($urandom_range(0, 19))
         0: return EVT_SYNC;
         1, 2: return EVT_XFER_BEGIN;
         3, 4: return EVT_XFER_DONE;
         5: return EVT_WRITE_DONE;
         6: return 3'($urandom_range(5, 7));
         default: return EVT_NONE;
      endcase
   endfunction

   // Button held or released in runs, events sprinkled in
   task automatic run_random_ticks(input int count, input int max_run);
      int   run_left;
      logic level;
      run_left = 0;
      level    = 1'b0;
      repeat (count) begin
         if (run_left == 0) begin
            level    = ~level;
            run_left = $urandom_range(1, max_run);
         end
         run_left--;
         send_tick(level, pick_event());
      end
   endtask

   task automatic test_reset_defaults();
      send_tick(1'b0, EVT_NONE);
      send_tick(1'b1, EVT_NONE);
      send_tick(1'b0, 3'd7);
      settle();
   endtask

   task automatic test_mode_events();
      write_csr(CSR_HOLD_TICKS, '1);
      write_blink(24'd2, 24'd5, 24'd3, 24'd4, 24'd1, 24'd3);
      // comms end before any sync falls back to slow
      send_tick(1'b0, EVT_XFER_BEGIN);
      send_tick(1'b0, EVT_XFER_DONE);
      send_tick(1'b1, EVT_WRITE_DONE);
      send_tick(1'b1, EVT_NONE);
      send_tick(1'b0, EVT_SYNC);
      send_tick(1'b0, EVT_XFER_BEGIN);
      send_tick(1'b0, EVT_XFER_DONE);
      send_tick(1'b0, 3'd5);
      send_tick(1'b1, 3'd6);
      send_tick(1'b0, EVT_NONE);
      settle();
   endtask

   task automatic test_blink_extremes();
      // zero on time, full on time, shortest and longest periods, zero period
      write_blink('0, 24'd1, '1, '1, 24'd1, '0);
      send_tick(1'b0, EVT_XFER_DONE);
      send_tick(1'b0, EVT_NONE);
      send_tick(1'b0, EVT_XFER_BEGIN);
      send_tick(1'b0, EVT_NONE);
      settle();
      write_blink('1, '0, '0, 24'd1, '1, 24'd1);
      send_tick(1'b0, EVT_SYNC);
      send_tick(1'b0, EVT_XFER_BEGIN);
      send_tick(1'b0, EVT_NONE);
      settle();
   endtask

   task automatic test_hold_boundary();
      // hold_count reaches the limit but does not exceed it
      write_csr(CSR_HOLD_TICKS, 32'd5);
      repeat (6) send_tick(1'b1, EVT_NONE);
      send_tick(1'b0, EVT_NONE);
      settle();
   endtask

   task automatic test_random_settings();
      for (int round = 0; round < 7; round++) begin
         if ($urandom_range(0, 1) == 0)
            write_csr(CSR_HOLD_TICKS, '1);
         else
            write_csr(CSR_HOLD_TICKS, $urandom_range(64, 32'hFFFF_FFFE));
         write_blink(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                     pick_ticks(), pick_ticks());
         run_random_ticks(95, 12);
         settle();
      end
   endtask

   task automatic test_shutdown_latch();
      calm = 1'b1;
      write_csr(CSR_HOLD_TICKS, 32'd5);
      repeat (7) send_tick(1'b1, pick_event());
      send_tick(1'b0, EVT_NONE);
      settle();
      write_csr(CSR_HOLD_TICKS, '0);
      write_blink(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                  pick_ticks(), pick_ticks());
      run_random_ticks(70, 6);
      settle();
   endtask

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.button_pressed = 1'b0;
      req_ch.event_req      = EVT_NONE;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = CSR_HOLD_TICKS;
      csr_ch.data           = '0;
      rsp_ch.ready          = 1'b1;
      stall_left            = 0;
      calm                  = 1'b0;
      error_count           = 0;
      cycle_count           = 0;
      ticks_sent            = 0;
      results_checked       = 0;
      csr_writes            = 0;
      hold_limit            = RST_HOLD_TICKS;
      lit_ticks[MODE_SLOW]      = RST_SLOW_ON;
      period_len[MODE_SLOW]     = RST_SLOW_PERIOD;
      lit_ticks[MODE_IDLE]      = RST_IDLE_ON;
      period_len[MODE_IDLE]     = RST_IDLE_PERIOD;
      lit_ticks[MODE_TRANSFER]  = RST_TRANSFER_ON;
      period_len[MODE_TRANSFER] = RST_TRANSFER_PERIOD;
      for (int i = 0; i < NUM_PHASE; i++)
         phase_cnt[i] = '0;
      blink_mode    = MODE_SLOW;
      sync_seen     = 1'b0;
      press_held    = 1'b0;
      held_ticks    = '0;
      shutdown_flag = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_mode_events();
      test_blink_extremes();
      test_hold_boundary();
      test_random_settings();
      test_shutdown_latch();

      repeat (10) @(posedge clock);
      $display("%0d ticks sent, %0d results checked, %0d register writes", ticks_sent,
               results_checked, csr_writes);
      $display("covered all events, blink extremes, hold boundary and shutdown latch");
      if (error_count == 0)
         $display("status_led_mode_and_hold_shutdown regression: pass");
      else
         $display("status_led_mode_and_hold_shutdown regression: fail");
      $finish;
   end

endmodule
